>>> rtl/jrld_pkg.sv
// ---------------------------------------------------------------------------
// jrld_pkg
// Shared types, symbol codes and magnitude decoding for the coefficient
// run-length decoder.
// ---------------------------------------------------------------------------
package jrld_pkg;

   localparam logic [7:0] SYM_EOB     = 8'h00;
   localparam logic [7:0] SYM_ZRL     = 8'hF0;
   localparam logic [5:0] BLOCK_LAST  = 6'd63;
   localparam logic [5:0] ZRL_FILL    = 6'd15;
   localparam logic [5:0] ZRL_LIMIT   = 6'd48;
   localparam int         MAG_WIDTH   = 17;

   // one command from the front: fill zeros from pos, then one closing word
   typedef struct packed {
      logic [5:0] pos;
      logic [5:0] fill;
      logic       last;
      logic       err;
   } jrld_cmd_type;

   // jpeg magnitude category decoding, size 0 gives 0
   function automatic logic signed [MAG_WIDTH-1:0] jrld_magnitude(
      input logic [3:0]  size,
      input logic [14:0] extra
   );
      logic [15:0] full;
      logic [15:0] top;
      logic [15:0] bits;
      logic signed [MAG_WIDTH-1:0] res;
      full = (16'd1 << size) - 16'd1;
      top  = full ^ (full >> 1);
      bits = {1'b0, extra} & full;
      if (size == 4'd0) begin
         res = '0;
      end else if ((bits & top) != 16'd0) begin
         res = $signed({1'b0, bits});
      end else begin
         res = $signed({1'b0, bits}) - $signed({1'b0, full});
      end
      return res;
   endfunction

endpackage

>>> rtl/jpeg_coefficient_run_length_decoder.sv
// ---------------------------------------------------------------------------
// jpeg_coefficient_run_length_decoder
// Rebuilds zigzag-ordered coefficient blocks from decoded jpeg symbols.
// ---------------------------------------------------------------------------
// The front end takes one symbol per cycle while its two-entry command queue
// has room, updates the block position and dc predictor in that cycle, and
// queues one command. The back end sends one coefficient word per cycle while
// rsp_stall is low, so a symbol yields (zero run + 1) words: one for dc and a
// coded coefficient, run + 1 for run/size symbols, 16 for zrl, 64 - position
// for eob, one for any error word. Sustained symbol rate is set by that word
// count; a symbol passes the queue and the command and output registers.
// Error words (bad symbol, run past the block end, bad component) carry last
// and end the block; the next symbol is taken as dc.
module jpeg_coefficient_run_length_decoder #(
   parameter int NUM_COMPONENTS = 3,
   parameter int COEFF_WIDTH    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_component,
   input  logic [7:0]                    req_symbol,
   input  logic [14:0]                   req_extra_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [5:0]                    rsp_position,
   output logic signed [COEFF_WIDTH-1:0] rsp_coefficient,
   output logic                          rsp_last,
   output logic                          rsp_error
);
   import jrld_pkg::*;

   localparam int QW = $bits(jrld_cmd_type) + COEFF_WIDTH;

   jrld_cmd_type                  f_cmd;
   logic signed [COEFF_WIDTH-1:0] f_value;
   jrld_cmd_type                  h_cmd;
   logic signed [COEFF_WIDTH-1:0] h_value;
   logic [QW-1:0]                 head_data;
   logic                          q_full;
   logic                          q_empty;
   logic                          push;
   logic                          pop;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   jrld_front #(
      .NUM_COMPONENTS (NUM_COMPONENTS),
      .COEFF_WIDTH    (COEFF_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_component  (req_component),
      .req_symbol     (req_symbol),
      .req_extra_bits (req_extra_bits),
      .accept         (!q_full),
      .cmd            (f_cmd),
      .cmd_value      (f_value)
   );

   jrld_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_cmd, f_value}),
      .pop       (pop),
      .head_data (head_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign h_cmd   = head_data[QW-1:COEFF_WIDTH];
   assign h_value = head_data[COEFF_WIDTH-1:0];

   jrld_back #(
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (!q_empty),
      .head_cmd        (h_cmd),
      .head_value      (h_value),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   // an error word always closes the block
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last)
      else $error("error word without last");

   // a clean block ends only at the final zigzag slot
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_error |-> rsp_position == BLOCK_LAST)
      else $error("block closed early without error");

   // nothing but the closing word may sit at the final slot
   a_pos_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_position != BLOCK_LAST)
      else $error("word at final slot not marked last");

   // an accepted symbol leaves a command in the queue
   a_queue: assert property (@(posedge clock) disable iff (reset)
      push |=> !q_empty)
      else $error("command lost in queue");

endmodule

>>> rtl/jrld_front.sv
// ---------------------------------------------------------------------------
// jrld_front
// Takes one symbol a cycle while accept is high, tracks block position and
// dc predictors, turning each symbol into a back-end fill-and-close command.
// ---------------------------------------------------------------------------
module jrld_front #(
   parameter int NUM_COMPONENTS = 3,
   parameter int COEFF_WIDTH    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [1:0]                     req_component,
   input  logic [7:0]                     req_symbol,
   input  logic [14:0]                    req_extra_bits,
   input  logic                           accept,
   output jrld_pkg::jrld_cmd_type         cmd,
   output logic signed [COEFF_WIDTH-1:0]  cmd_value
);
   import jrld_pkg::*;

   localparam int SW   = ((COEFF_WIDTH > MAG_WIDTH) ? COEFF_WIDTH : MAG_WIDTH) + 1;
   localparam int IDXW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW - COEFF_WIDTH + 1){1'b0}}, {(COEFF_WIDTH - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   logic [5:0]                    pos_ff;
   logic [5:0]                    pos_in;
   logic signed [COEFF_WIDTH-1:0] pred_ff [NUM_COMPONENTS];
   logic                          pred_we;

   logic [3:0]                    run;
   logic [3:0]                    size;
   logic [6:0]                    run_end;
   logic                          bad_comp;
   logic [IDXW-1:0]               comp_idx;
   logic signed [MAG_WIDTH-1:0]   mag;
   logic signed [SW-1:0]          pre_sat;
   logic signed [COEFF_WIDTH-1:0] sat_val;

   assign run      = req_symbol[7:4];
   assign size     = req_symbol[3:0];
   assign run_end  = {1'b0, pos_ff} + {3'b000, run};
   assign bad_comp = {1'b0, req_component} >= 3'(NUM_COMPONENTS);
   assign comp_idx = req_component[IDXW-1:0];
   assign mag      = jrld_magnitude(size, req_extra_bits);

   always_comb begin
      if (pos_ff == 6'd0 && !bad_comp) begin
         pre_sat = SW'(pred_ff[comp_idx]) + SW'(mag);
      end else begin
         pre_sat = SW'(mag);
      end
      if (pre_sat > SAT_HI) begin
         sat_val = COEFF_WIDTH'(SAT_HI);
      end else if (pre_sat < SAT_LO) begin
         sat_val = COEFF_WIDTH'(SAT_LO);
      end else begin
         sat_val = COEFF_WIDTH'(pre_sat);
      end
   end

   // classify the symbol; defaults describe an aborted block
   always_comb begin
      cmd.pos   = pos_ff;
      cmd.fill  = 6'd0;
      cmd.last  = 1'b1;
      cmd.err   = 1'b1;
      cmd_value = '0;
      pos_in    = 6'd0;
      pred_we   = 1'b0;
      if (pos_ff == 6'd0) begin
         if (!bad_comp) begin
            cmd.last  = 1'b0;
            cmd.err   = 1'b0;
            cmd_value = sat_val;
            pos_in    = 6'd1;
            pred_we   = 1'b1;
         end
      end else if (req_symbol == SYM_EOB) begin
         cmd.fill = BLOCK_LAST - pos_ff;
         cmd.err  = 1'b0;
      end else if (req_symbol == SYM_ZRL) begin
         if (pos_ff <= ZRL_LIMIT) begin
            cmd.fill = ZRL_FILL;
            cmd.err  = 1'b0;
            cmd.last = (pos_ff == ZRL_LIMIT);
            pos_in   = pos_ff + 6'd16;
         end
      end else if (size != 4'd0 && run_end <= 7'(BLOCK_LAST)) begin
         cmd.fill  = {2'b00, run};
         cmd.err   = 1'b0;
         cmd.last  = (run_end == 7'(BLOCK_LAST));
         cmd_value = sat_val;
         pos_in    = run_end[5:0] + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
         for (int i = 0; i < NUM_COMPONENTS; i++) begin
            pred_ff[i] <= '0;
         end
      end else if (accept && req_valid) begin
         pos_ff <= pos_in;
         if (pred_we) begin
            pred_ff[comp_idx] <= sat_val;
         end
      end
   end

endmodule

>>> rtl/jrld_fifo.sv
// ---------------------------------------------------------------------------
// jrld_fifo
// Two-entry command queue between the front and back ends.
// ---------------------------------------------------------------------------
module jrld_fifo #(
   parameter int WIDTH = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

endmodule

>>> rtl/jrld_back.sv
// ---------------------------------------------------------------------------
// jrld_back
// Expands queued commands into one coefficient word per cycle unless stalled:
// zero fill first, then the closing word, through a registered output stage.
// ---------------------------------------------------------------------------
module jrld_back #(
   parameter int COEFF_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  jrld_pkg::jrld_cmd_type         head_cmd,
   input  logic signed [COEFF_WIDTH-1:0]  head_value,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [5:0]                     rsp_position,
   output logic signed [COEFF_WIDTH-1:0]  rsp_coefficient,
   output logic                           rsp_last,
   output logic                           rsp_error
);
   import jrld_pkg::*;

   logic                          act_ff,   act_in;
   logic [5:0]                    cur_ff,   cur_in;
   logic [5:0]                    left_ff,  left_in;
   logic signed [COEFF_WIDTH-1:0] tval_ff,  tval_in;
   logic                          tlast_ff, tlast_in;
   logic                          terr_ff,  terr_in;

   logic                          vld_ff,   vld_in;
   logic [5:0]                    opos_ff,  opos_in;
   logic signed [COEFF_WIDTH-1:0] ocoef_ff, ocoef_in;
   logic                          olast_ff, olast_in;
   logic                          oerr_ff,  oerr_in;

   logic out_ready;
   logic emit;
   logic closing;

   assign out_ready = !vld_ff || !rsp_stall;
   assign emit      = act_ff && out_ready;
   assign closing   = (left_ff == 6'd0);
   assign pop       = head_valid && (!act_ff || (emit && closing));

   always_comb begin
      act_in   = act_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      tval_in  = tval_ff;
      tlast_in = tlast_ff;
      terr_in  = terr_ff;
      vld_in   = vld_ff;
      opos_in  = opos_ff;
      ocoef_in = ocoef_ff;
      olast_in = olast_ff;
      oerr_in  = oerr_ff;
      if (emit) begin
         vld_in  = 1'b1;
         opos_in = cur_ff;
         if (closing) begin
            ocoef_in = tval_ff;
            olast_in = tlast_ff;
            oerr_in  = terr_ff;
            act_in   = 1'b0;
         end else begin
            ocoef_in = '0;
            olast_in = 1'b0;
            oerr_in  = 1'b0;
            cur_in   = cur_ff + 6'd1;
            left_in  = left_ff - 6'd1;
         end
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
      // next command is loaded as the closing word goes out, or while idle
      if (pop) begin
         act_in   = 1'b1;
         cur_in   = head_cmd.pos;
         left_in  = head_cmd.fill;
         tval_in  = head_value;
         tlast_in = head_cmd.last;
         terr_in  = head_cmd.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         vld_ff <= vld_in;
      end
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      tval_ff  <= tval_in;
      tlast_ff <= tlast_in;
      terr_ff  <= terr_in;
      opos_ff  <= opos_in;
      ocoef_ff <= ocoef_in;
      olast_ff <= olast_in;
      oerr_ff  <= oerr_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_position    = opos_ff;
   assign rsp_coefficient = ocoef_ff;
   assign rsp_last        = olast_ff;
   assign rsp_error       = oerr_ff;

endmodule

>>> tb/jpeg_coefficient_run_length_decoder_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// jpeg_coefficient_run_length_decoder_test
// Sends dc/ac symbol streams into the run-length decoder and checks every
// coefficient word against a block predictor kept in a small scoreboard.
// A directed part covers the edge cases, then well-formed random blocks with
// some noise follow. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
import jrld_pkg::*;

typedef struct {
   logic [5:0]         position;
   logic signed [15:0] coefficient;
   logic               last;
   logic               error;
} coeff_word_type;

class coefficient_scoreboard;
   localparam int COMPONENTS = 3;

   coeff_word_type     pending[$];
   logic [5:0]         block_pos;
   logic signed [15:0] dc_pred[COMPONENTS];
   int                 symbols_noted;
   int                 words_checked;
   int                 error_words;
   int                 blocks_closed;
   int                 mismatches;

   function new();
      block_pos = '0;
      foreach (dc_pred[k]) dc_pred[k] = '0;
      symbols_noted = 0;
      words_checked = 0;
      error_words   = 0;
      blocks_closed = 0;
      mismatches    = 0;
   endfunction

   // category decoding: low half of the range is negative
   function int magnitude_of(int size, int extra);
      int full;
      int bits;
      if (size == 0) return 0;
      full = (1 << size) - 1;
      bits = extra & full;
      if (bits >= (1 << (size - 1))) return bits;
      return bits - full;
   endfunction

   function logic signed [15:0] clamp16(int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function void push_word(int pos, logic signed [15:0] coef, logic last, logic err);
      coeff_word_type w;
      w.position    = pos[5:0];
      w.coefficient = coef;
      w.last        = last;
      w.error       = err;
      pending.push_back(w);
   endfunction

   function void note_symbol(logic [1:0] comp, logic [7:0] sym, logic [14:0] extra);
      int p;
      int run;
      int size;
      int i;
      p    = block_pos;
      run  = sym[7:4];
      size = sym[3:0];
      symbols_noted++;
      if (p == 0) begin
         if (comp >= COMPONENTS) begin
            push_word(0, 16'sd0, 1'b1, 1'b1);
            return;
         end
         dc_pred[comp] = clamp16(int'(dc_pred[comp]) + magnitude_of(size, int'(extra)));
         push_word(0, dc_pred[comp], 1'b0, 1'b0);
         block_pos = 6'd1;
         return;
      end
      if (sym == SYM_EOB) begin
         for (i = p; i < 64; i++) push_word(i, 16'sd0, i == 63, 1'b0);
         block_pos = 6'd0;
         return;
      end
      if (sym == SYM_ZRL) begin
         if (p + 15 > 63) begin
            push_word(p, 16'sd0, 1'b1, 1'b1);
            block_pos = 6'd0;
            return;
         end
         for (i = p; i < p + 16; i++) push_word(i, 16'sd0, i == 63, 1'b0);
         block_pos = 6'(p + 16);
         return;
      end
      // size-0 symbol other than eob/zrl, or run past the block end
      if (size == 0 || p + run > 63) begin
         push_word(p, 16'sd0, 1'b1, 1'b1);
         block_pos = 6'd0;
         return;
      end
      for (i = p; i < p + run; i++) push_word(i, 16'sd0, 1'b0, 1'b0);
      i = p + run;
      push_word(i, clamp16(magnitude_of(size, int'(extra))), i == 63, 1'b0);
      block_pos = 6'(i + 1);
   endfunction

   function void check_word(logic [5:0] pos, logic signed [15:0] coef,
                            logic got_last, logic got_error);
      coeff_word_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected word position %0d coefficient %0d last %0b error %0b",
                  $time, pos, coef, got_last, got_error);
         mismatches++;
         return;
      end
      want = pending.pop_front();
      words_checked++;
      if (want.error) error_words++;
      if (want.last) blocks_closed++;
      if (pos !== want.position) begin
         $display("%0t: position expected %0d got %0d", $time, want.position, pos);
         mismatches++;
      end
      if (coef !== want.coefficient) begin
         $display("%0t: coefficient at %0d expected %0d got %0d",
                  $time, want.position, want.coefficient, coef);
         mismatches++;
      end
      if (got_last !== want.last) begin
         $display("%0t: last at %0d expected %0b got %0b",
                  $time, want.position, want.last, got_last);
         mismatches++;
      end
      if (got_error !== want.error) begin
         $display("%0t: error at %0d expected %0b got %0b",
                  $time, want.position, want.error, got_error);
         mismatches++;
      end
   endfunction
endclass

module jpeg_coefficient_run_length_decoder_test;

   localparam int RANDOM_SYMBOLS = 330;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_LIMIT    = 200000;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [1:0]         req_component  = '0;
   logic [7:0]         req_symbol     = '0;
   logic [14:0]        req_extra_bits = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [5:0]         rsp_position;
   logic signed [15:0] rsp_coefficient;
   logic               rsp_last;
   logic               rsp_error;

   coefficient_scoreboard sb;
   logic               long_hold_req = 1'b0;
   int                 burst_left    = 0;
   int                 no_gap_left   = 0;

   jpeg_coefficient_run_length_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_component   (req_component),
      .req_symbol      (req_symbol),
      .req_extra_bits  (req_extra_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .rsp_coefficient (rsp_coefficient),
      .rsp_last        (rsp_last),
      .rsp_error       (rsp_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_position, rsp_coefficient, rsp_last, rsp_error);
   end

   // receiver: stall density changes every so often, plus one long hold
   initial begin : receiver
      int   mode_left;
      int   stall_pct;
      int   hold_left;
      logic hold_taken;
      mode_left  = 0;
      stall_pct  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 80;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_symbol(logic [1:0] comp, logic [7:0] sym, logic [14:0] extra);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_component  <= comp;
      req_symbol     <= sym;
      req_extra_bits <= extra;
      do @(posedge clock); while (req_stall);
      sb.note_symbol(comp, sym, extra);
   endtask

   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic pace_sender();
      if (no_gap_left > 0) begin
         no_gap_left--;
         return;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         idle_sender($urandom_range(0, 10));
      end
      burst_left--;
   endtask

   // mostly well-formed blocks from the current position, some noise
   task automatic choose_symbol(output logic [1:0] comp, output logic [7:0] sym,
                                output logic [14:0] extra);
      int p;
      int room;
      int run;
      int size;
      int roll;
      p     = sb.block_pos;
      roll  = $urandom_range(0, 99);
      extra = 15'($urandom_range(0, 32767));
      comp  = 2'($urandom_range(0, 2));
      size  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15) : $urandom_range(1, 11);
      if (roll < 5) begin
         comp = 2'($urandom_range(0, 3));
         sym  = 8'($urandom_range(0, 255));
      end else if (p == 0) begin
         if (roll < 8) comp = 2'd3;
         if (roll >= 90) size = 0;
         sym = {4'($urandom_range(0, 15)), 4'(size)};
      end else if (roll < 17) begin
         sym = SYM_EOB;
      end else if (roll < 25 && p <= 48) begin
         sym = SYM_ZRL;
      end else begin
         room = 63 - p;
         if (room > 15) room = 15;
         if ($urandom_range(0, 2) == 0) run = $urandom_range(0, room);
         else run = $urandom_range(0, (room < 3) ? room : 3);
         sym = {4'(run), 4'(size)};
      end
   endtask

   initial begin : stimulus
      logic [1:0]  comp;
      logic [7:0]  sym;
      logic [14:0] extra;
      int          drain;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // largest dc, longest run with largest negative, run overrun at 49
      send_symbol(2'd0, 8'h0F, 15'h7FFF);
      send_symbol(2'd0, 8'hFF, 15'h0000);
      send_symbol(2'd0, SYM_ZRL, 15'h0000);
      send_symbol(2'd0, SYM_ZRL, 15'h7FFF);
      send_symbol(2'd0, 8'hFF, 15'h7FFF);
      // dc saturates high, then a size-0 ac symbol
      send_symbol(2'd0, 8'h0F, 15'h7FFF);
      send_symbol(2'd0, 8'h10, 15'h7FFF);
      // bad component on a dc symbol
      send_symbol(2'd3, 8'h05, 15'h0011);
      send_symbol(2'd1, 8'h0F, 15'h0000);
      send_symbol(2'd1, SYM_EOB, 15'h7FFF);
      // dc saturates low, zrl lands on the last position
      send_symbol(2'd1, 8'h0F, 15'h0000);
      send_symbol(2'd0, 8'hF1, 15'h0001);
      send_symbol(2'd0, SYM_ZRL, 15'h0000);
      send_symbol(2'd0, 8'hE1, 15'h7FFE);
      send_symbol(2'd0, SYM_ZRL, 15'h0000);
      // size-0 dc, then zrl past the block end
      send_symbol(2'd2, SYM_EOB, 15'h7FFF);
      send_symbol(2'd2, 8'hF1, 15'h7FFF);
      send_symbol(2'd2, SYM_ZRL, 15'h0000);
      send_symbol(2'd2, SYM_ZRL, 15'h0000);
      send_symbol(2'd2, SYM_ZRL, 15'h0000);
      // unused high extra bits, coefficient on the last position
      send_symbol(2'd2, 8'h03, 15'h7FF8);
      send_symbol(2'd1, 8'hF2, 15'h0002);
      send_symbol(2'd1, SYM_ZRL, 15'h0000);
      send_symbol(2'd1, SYM_ZRL, 15'h0000);
      send_symbol(2'd1, 8'hE5, 15'h0010);

      for (int n = 0; n < RANDOM_SYMBOLS; n++) begin
         if (n == 100) begin
            // output held off while input keeps coming
            long_hold_req = 1'b1;
            no_gap_left = 40;
         end
         if (n == 220) begin
            idle_sender(1);
            while (sb.pending.size() != 0) @(posedge clock);
         end
         pace_sender();
         choose_symbol(comp, sym, extra);
         send_symbol(comp, sym, extra);
      end
      idle_sender(1);

      drain = 0;
      while (sb.pending.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      while (sb.pending.size() != 0) begin
         $display("%0t: missing word at position %0d", $time, sb.pending[0].position);
         void'(sb.pending.pop_front());
         sb.mismatches++;
      end

      $display("run covered %0d symbols and %0d coefficient words", sb.symbols_noted,
               sb.words_checked);
      $display("blocks ended: %0d, of them by an error word: %0d", sb.blocks_closed,
               sb.error_words);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> jpeg_coefficient_run_length_decoder.f
rtl/jrld_pkg.sv
rtl/jrld_front.sv
rtl/jrld_fifo.sv
rtl/jrld_back.sv
rtl/jpeg_coefficient_run_length_decoder.sv
tb/jpeg_coefficient_run_length_decoder_test.sv
